@@ rtl/core/owb_pkg.sv @@
// Shared types, codes and reset values for the single-wire bus master.
`timescale 1ns / 1ps

package owb_pkg;

    localparam int TIME_W = 10;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PIN_RELEASED = 2'd0,
        PIN_LOW      = 2'd1,
        PIN_HIGH     = 2'd2
    } pin_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW_TIME    = 3'd0,
        REG_PRESENCE_DELAY    = 3'd1,
        REG_PRESENCE_TIMEOUT  = 3'd2,
        REG_RESET_RECOVERY    = 3'd3,
        REG_WRITE_START_LOW   = 3'd4,
        REG_WRITE_SLOT_TIME   = 3'd5,
        REG_READ_LOW_TIME     = 3'd6,
        REG_READ_SAMPLE_DELAY = 3'd7
    } reg_idx_t;

    localparam logic [TIME_W-1:0] RST_RESET_LOW_TIME    = 10'd750;
    localparam logic [TIME_W-1:0] RST_PRESENCE_DELAY    = 10'd15;
    localparam logic [TIME_W-1:0] RST_PRESENCE_TIMEOUT  = 10'd500;
    localparam logic [TIME_W-1:0] RST_RESET_RECOVERY    = 10'd480;
    localparam logic [TIME_W-1:0] RST_WRITE_START_LOW   = 10'd2;
    localparam logic [TIME_W-1:0] RST_WRITE_SLOT_TIME   = 10'd60;
    localparam logic [TIME_W-1:0] RST_READ_LOW_TIME     = 10'd5;
    localparam logic [TIME_W-1:0] RST_READ_SAMPLE_DELAY = 10'd12;

    localparam logic [TIME_W-1:0] ZERO_TAIL_TIME = 10'd2;
    localparam logic [TIME_W-1:0] READ_TAIL_TIME = 10'd50;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_delay;
        logic [TIME_W-1:0] presence_timeout;
        logic [TIME_W-1:0] reset_recovery;
        logic [TIME_W-1:0] write_start_low;
        logic [TIME_W-1:0] write_slot_time;
        logic [TIME_W-1:0] read_low_time;
        logic [TIME_W-1:0] read_sample_delay;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        drive_mode;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              presence_missing;
    } res_t;

endpackage

@@ rtl/core/owb_if.sv @@
// Command and result channel interfaces of the single-wire bus master.
`timescale 1ns / 1ps

interface owb_cmd_if
    import owb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] write_data;
    logic              line_level;

    modport source (output valid, output operation, output write_data, output line_level,
                    input ready);
    modport sink (input valid, input operation, input write_data, input line_level,
                  output ready);
endinterface

interface owb_res_if
    import owb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [1:0]        drive_mode;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              presence_missing;

    modport source (output valid, output drive_mode, output busy_res, output done_res,
                    output read_byte, output presence_missing, input ready);
    modport sink (input valid, input drive_mode, input busy_res, input done_res,
                  input read_byte, input presence_missing, output ready);
endinterface

@@ rtl/core/one_wire_bus_master.sv @@
// Top level of the single-wire bus master: input stage, sequencer and result stage.
// An accepted beat is held in the input register; its result is registered at the output.
// Throughput: one beat per cycle while results are taken; a tick beat steps the bus timers.
// The next beat is taken while a result waits in the output register.
// Reset (rst_n, asynchronous, active low): line released, idle, registers at defaults.
`timescale 1ns / 1ps

module one_wire_bus_master
    import owb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    owb_cmd_if.sink           cmd,
    owb_res_if.source         res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    res_t              seq_res;
    res_t              res_reg;
    logic              in_valid_reg;
    logic [1:0]        op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              level_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              advance;
    logic              cmd_take;

    owb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owb_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .operation  (op_reg),
        .write_data (data_reg),
        .line_level (level_reg),
        .cfg        (cfg),
        .result     (seq_res)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the beat until the sequencer takes it
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg    <= cmd.operation;
            data_reg  <= cmd.write_data;
            level_reg <= cmd.line_level;
        end
        if (advance)
            res_reg <= seq_res;
    end

    assign res.valid            = out_valid_reg;
    assign res.drive_mode       = res_reg.drive_mode;
    assign res.busy_res         = res_reg.busy_res;
    assign res.done_res         = res_reg.done_res;
    assign res.read_byte        = res_reg.read_byte;
    assign res.presence_missing = res_reg.presence_missing;

endmodule

@@ rtl/core/owb_cfg_regs.sv @@
// APB-style timing register file of the single-wire bus master.
`timescale 1ns / 1ps

module owb_cfg_regs
    import owb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t              cfg_reg;
    logic              wr_en;
    reg_idx_t          idx;
    logic [TIME_W-1:0] wval;
    logic [TIME_W-1:0] rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wval   = pwdata[TIME_W-1:0];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time    <= RST_RESET_LOW_TIME;
            cfg_reg.presence_delay    <= RST_PRESENCE_DELAY;
            cfg_reg.presence_timeout  <= RST_PRESENCE_TIMEOUT;
            cfg_reg.reset_recovery    <= RST_RESET_RECOVERY;
            cfg_reg.write_start_low   <= RST_WRITE_START_LOW;
            cfg_reg.write_slot_time   <= RST_WRITE_SLOT_TIME;
            cfg_reg.read_low_time     <= RST_READ_LOW_TIME;
            cfg_reg.read_sample_delay <= RST_READ_SAMPLE_DELAY;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_RESET_LOW_TIME:    cfg_reg.reset_low_time    <= wval;
                REG_PRESENCE_DELAY:    cfg_reg.presence_delay    <= wval;
                REG_PRESENCE_TIMEOUT:  cfg_reg.presence_timeout  <= wval;
                REG_RESET_RECOVERY:    cfg_reg.reset_recovery    <= wval;
                REG_WRITE_START_LOW:   cfg_reg.write_start_low   <= wval;
                REG_WRITE_SLOT_TIME:   cfg_reg.write_slot_time   <= wval;
                REG_READ_LOW_TIME:     cfg_reg.read_low_time     <= wval;
                REG_READ_SAMPLE_DELAY: cfg_reg.read_sample_delay <= wval;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_RESET_LOW_TIME:    rval = cfg_reg.reset_low_time;
            REG_PRESENCE_DELAY:    rval = cfg_reg.presence_delay;
            REG_PRESENCE_TIMEOUT:  rval = cfg_reg.presence_timeout;
            REG_RESET_RECOVERY:    rval = cfg_reg.reset_recovery;
            REG_WRITE_START_LOW:   rval = cfg_reg.write_start_low;
            REG_WRITE_SLOT_TIME:   rval = cfg_reg.write_slot_time;
            REG_READ_LOW_TIME:     rval = cfg_reg.read_low_time;
            REG_READ_SAMPLE_DELAY: rval = cfg_reg.read_sample_delay;
            default:               rval = '0;
        endcase
    end

    assign prdata = {{(DATA_W-TIME_W){1'b0}}, rval};

endmodule

@@ rtl/core/owb_sequencer.sv @@
// Bus phase sequencer: holds the protocol state and works out each beat's next state.
`timescale 1ns / 1ps

module owb_sequencer
    import owb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        operation,
    input  logic [BYTE_W-1:0] write_data,
    input  logic              line_level,
    input  cfg_t              cfg,
    output res_t              result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_POLL, PH_RST_RECOVER,
        PH_WR_LOW, PH_WR_DATA, PH_WR_TAIL,
        PH_RD_LOW, PH_RD_WAIT, PH_RD_SAMPLE, PH_RD_TAIL
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [BIT_W-1:0] bit_idx;
        pin_t             pin;
        logic             done;
        logic             fail;
    } move_t;

    localparam logic [BIT_W-1:0] LAST_BIT = {BIT_W{1'b1}};

    phase_t            phase_reg;
    logic [TIME_W-1:0] tick_count_reg;
    logic [BIT_W-1:0]  bit_index_reg;
    logic [BYTE_W-1:0] shift_byte_reg;
    pin_t              pin_reg;
    logic              missing_reg;
    logic [BYTE_W-1:0] read_result_reg;

    move_t             mv;
    logic [TIME_W-1:0] tick_count_next;
    logic [BYTE_W-1:0] shift_byte_next;
    logic              missing_next;
    logic [BYTE_W-1:0] read_result_next;
    logic [TIME_W-1:0] cnt_inc;
    logic [TIME_W-1:0] dur;
    op_t               op;

    function automatic move_t mk(phase_t p, logic [BIT_W-1:0] b, pin_t pin, logic d, logic f);
        move_t m;
        m.phase   = p;
        m.bit_idx = b;
        m.pin     = pin;
        m.done    = d;
        m.fail    = f;
        return m;
    endfunction

    function automatic move_t rst_poll_enter(cfg_t c);
        if (c.presence_timeout != '0)
            return mk(PH_RST_POLL, '0, PIN_RELEASED, 1'b0, 1'b0);
        return mk(PH_IDLE, '0, PIN_RELEASED, 1'b1, 1'b1);
    endfunction

    function automatic move_t rst_wait_enter(cfg_t c);
        if (c.presence_delay != '0)
            return mk(PH_RST_WAIT, '0, PIN_RELEASED, 1'b0, 1'b0);
        return rst_poll_enter(c);
    endfunction

    function automatic move_t rst_enter(cfg_t c);
        if (c.reset_low_time != '0)
            return mk(PH_RST_LOW, '0, PIN_LOW, 1'b0, 1'b0);
        return rst_wait_enter(c);
    endfunction

    function automatic move_t recover_enter(cfg_t c);
        if (c.reset_recovery != '0)
            return mk(PH_RST_RECOVER, '0, PIN_RELEASED, 1'b0, 1'b0);
        return mk(PH_IDLE, '0, PIN_RELEASED, 1'b1, 1'b0);
    endfunction

    // Data phase of bit b onward, skipping every slot part whose time is zero.
    function automatic move_t wr_data_chain(cfg_t c, logic [BIT_W-1:0] b,
                                            logic [BYTE_W-1:0] d);
        logic             found;
        logic [BIT_W-1:0] k;
        found = 1'b0;
        k     = '0;
        if (c.write_slot_time != '0)
            return mk(PH_WR_DATA, b, d[b] ? PIN_HIGH : PIN_LOW, 1'b0, 1'b0);
        if (c.write_start_low != '0)
        begin
            if (!d[b])
                return mk(PH_WR_TAIL, b, PIN_HIGH, 1'b0, 1'b0);
            if (b == LAST_BIT)
                return mk(PH_IDLE, b, PIN_HIGH, 1'b1, 1'b0);
            return mk(PH_WR_LOW, b + 1'b1, PIN_LOW, 1'b0, 1'b0);
        end
        // both slot parts empty: run on to the first zero bit, which has a tail
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (!found && i >= int'(b) && !d[i])
            begin
                found = 1'b1;
                k     = BIT_W'(i);
            end
        end
        if (found)
            return mk(PH_WR_TAIL, k, PIN_HIGH, 1'b0, 1'b0);
        return mk(PH_IDLE, LAST_BIT, PIN_HIGH, 1'b1, 1'b0);
    endfunction

    function automatic move_t wr_enter(cfg_t c, logic [BIT_W-1:0] b, logic [BYTE_W-1:0] d);
        if (c.write_start_low != '0)
            return mk(PH_WR_LOW, b, PIN_LOW, 1'b0, 1'b0);
        return wr_data_chain(c, b, d);
    endfunction

    function automatic move_t wr_next_bit(cfg_t c, logic [BIT_W-1:0] b,
                                          logic [BYTE_W-1:0] d);
        if (b == LAST_BIT)
            return mk(PH_IDLE, b, PIN_HIGH, 1'b1, 1'b0);
        return wr_enter(c, b + 1'b1, d);
    endfunction

    function automatic move_t rd_wait_enter(cfg_t c, logic [BIT_W-1:0] b);
        if (c.read_sample_delay != '0)
            return mk(PH_RD_WAIT, b, PIN_RELEASED, 1'b0, 1'b0);
        return mk(PH_RD_SAMPLE, b, PIN_RELEASED, 1'b0, 1'b0);
    endfunction

    function automatic move_t rd_enter(cfg_t c, logic [BIT_W-1:0] b);
        if (c.read_low_time != '0)
            return mk(PH_RD_LOW, b, PIN_LOW, 1'b0, 1'b0);
        return rd_wait_enter(c, b);
    endfunction

    assign op      = op_t'(operation);
    assign cnt_inc = tick_count_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:     dur = cfg.reset_low_time;
            PH_RST_WAIT:    dur = cfg.presence_delay;
            PH_RST_RECOVER: dur = cfg.reset_recovery;
            PH_WR_LOW:      dur = cfg.write_start_low;
            PH_WR_DATA:     dur = cfg.write_slot_time;
            PH_WR_TAIL:     dur = ZERO_TAIL_TIME;
            PH_RD_LOW:      dur = cfg.read_low_time;
            PH_RD_WAIT:     dur = cfg.read_sample_delay;
            PH_RD_TAIL:     dur = READ_TAIL_TIME;
            default:        dur = 10'd1;
        endcase
    end

    always_comb
    begin
        mv               = mk(phase_reg, bit_index_reg, pin_reg, 1'b0, 1'b0);
        tick_count_next  = tick_count_reg;
        shift_byte_next  = shift_byte_reg;
        missing_next     = missing_reg;
        read_result_next = read_result_reg;
        if (step)
        begin
            if (op == OP_TICK)
            begin
                case (phase_reg)
                    PH_IDLE: ;
                    PH_RST_POLL:
                    begin
                        if (!line_level)
                        begin
                            mv              = recover_enter(cfg);
                            tick_count_next = '0;
                        end
                        else if (cnt_inc >= cfg.presence_timeout)
                        begin
                            mv              = mk(PH_IDLE, bit_index_reg, pin_reg, 1'b1, 1'b1);
                            tick_count_next = '0;
                        end
                        else
                            tick_count_next = cnt_inc;
                    end
                    PH_RD_SAMPLE:
                    begin
                        shift_byte_next = {line_level, shift_byte_reg[BYTE_W-1:1]};
                        mv              = mk(PH_RD_TAIL, bit_index_reg, PIN_RELEASED,
                                             1'b0, 1'b0);
                        tick_count_next = '0;
                    end
                    default:
                    begin
                        if (cnt_inc >= dur)
                        begin
                            tick_count_next = '0;
                            case (phase_reg)
                                PH_RST_LOW:     mv = rst_wait_enter(cfg);
                                PH_RST_WAIT:    mv = rst_poll_enter(cfg);
                                PH_RST_RECOVER: mv = mk(PH_IDLE, bit_index_reg, pin_reg,
                                                        1'b1, 1'b0);
                                PH_WR_LOW:      mv = wr_data_chain(cfg, bit_index_reg,
                                                                   shift_byte_reg);
                                PH_WR_DATA:
                                begin
                                    if (shift_byte_reg[bit_index_reg])
                                        mv = wr_next_bit(cfg, bit_index_reg, shift_byte_reg);
                                    else
                                        mv = mk(PH_WR_TAIL, bit_index_reg, PIN_HIGH,
                                                1'b0, 1'b0);
                                end
                                PH_WR_TAIL:     mv = wr_next_bit(cfg, bit_index_reg,
                                                                 shift_byte_reg);
                                PH_RD_LOW:      mv = rd_wait_enter(cfg, bit_index_reg);
                                PH_RD_WAIT:     mv = mk(PH_RD_SAMPLE, bit_index_reg,
                                                        PIN_RELEASED, 1'b0, 1'b0);
                                PH_RD_TAIL:
                                begin
                                    if (bit_index_reg == LAST_BIT)
                                    begin
                                        read_result_next = shift_byte_reg;
                                        mv = mk(PH_IDLE, bit_index_reg, pin_reg, 1'b1, 1'b0);
                                    end
                                    else
                                        mv = rd_enter(cfg, bit_index_reg + 1'b1);
                                end
                                default:        mv = mk(PH_IDLE, bit_index_reg, pin_reg,
                                                        1'b0, 1'b0);
                            endcase
                        end
                        else
                            tick_count_next = cnt_inc;
                    end
                endcase
            end
            else if (phase_reg == PH_IDLE)
            begin
                tick_count_next = '0;
                case (op)
                    OP_RESET:
                    begin
                        missing_next = 1'b0;
                        mv           = rst_enter(cfg);
                    end
                    OP_WRITE:
                    begin
                        shift_byte_next = write_data;
                        mv              = wr_enter(cfg, '0, write_data);
                    end
                    OP_READ:
                    begin
                        shift_byte_next = '0;
                        mv              = rd_enter(cfg, '0);
                    end
                    default: ;
                endcase
            end
            if (mv.fail)
                missing_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            pin_reg         <= PIN_RELEASED;
            missing_reg     <= 1'b0;
            read_result_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= mv.phase;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= mv.bit_idx;
            shift_byte_reg  <= shift_byte_next;
            pin_reg         <= mv.pin;
            missing_reg     <= missing_next;
            read_result_reg <= read_result_next;
        end
    end

    assign result.drive_mode       = mv.pin;
    assign result.busy_res         = (mv.phase != PH_IDLE);
    assign result.done_res         = mv.done;
    assign result.read_byte        = read_result_next;
    assign result.presence_missing = missing_next;

    a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && op == OP_TICK)
        |=> (phase_reg == PH_IDLE && $stable(pin_reg) && $stable(shift_byte_reg)))
        else $error("tick while idle changed the sequencer");

    a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg != PH_IDLE && op != OP_TICK)
        |=> ($stable(phase_reg) && $stable(tick_count_reg) && $stable(bit_index_reg)))
        else $error("command while busy disturbed the sequence");

    a_hold_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(read_result_reg) && $stable(missing_reg)))
        else $error("state moved without a beat");

    a_low_phase_drives_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RST_LOW || phase_reg == PH_WR_LOW || phase_reg == PH_RD_LOW)
        |-> (pin_reg == PIN_LOW))
        else $error("low phase without the line driven low");

endmodule

@@ verif/owb_scoreboard.sv @@
// Result scoreboard for the single-wire bus master: predicts every result beat and compares it.
`timescale 1ns / 1ps

module owb_scoreboard
    import owb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    owb_cmd_if                cmd,
    owb_res_if                res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                mismatches,
    output int                outstanding,
    output logic              bus_busy,
    output int                resets_run,
    output int                writes_run,
    output int                reads_run,
    output int                completions,
    output int                absent_count
);

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_POLL,
        SEQ_RST_RECOVER,
        SEQ_WR_LOW,
        SEQ_WR_DATA,
        SEQ_WR_TAIL,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_SAMPLE,
        SEQ_RD_TAIL
    } seq_t;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BYTE_W - 1);

    logic [TIME_W-1:0] timing [8];
    seq_t              seq;
    logic [TIME_W-1:0] elapsed;
    logic [BIT_W-1:0]  bit_pos;
    logic [BYTE_W-1:0] shreg;
    pin_t              pin;
    logic              absent;
    logic [BYTE_W-1:0] last_read;
    logic              done_now;
    res_t              awaited_results [$];

    function automatic logic is_timed(seq_t p);
        return p != SEQ_IDLE && p != SEQ_RST_POLL && p != SEQ_RD_SAMPLE;
    endfunction

    function automatic logic [TIME_W-1:0] phase_length(seq_t p);
        case (p)
            SEQ_RST_LOW:     return timing[REG_RESET_LOW_TIME];
            SEQ_RST_WAIT:    return timing[REG_PRESENCE_DELAY];
            SEQ_RST_RECOVER: return timing[REG_RESET_RECOVERY];
            SEQ_WR_LOW:      return timing[REG_WRITE_START_LOW];
            SEQ_WR_DATA:     return timing[REG_WRITE_SLOT_TIME];
            SEQ_WR_TAIL:     return ZERO_TAIL_TIME;
            SEQ_RD_LOW:      return timing[REG_READ_LOW_TIME];
            SEQ_RD_WAIT:     return timing[REG_READ_SAMPLE_DELAY];
            SEQ_RD_TAIL:     return READ_TAIL_TIME;
            default:         return TIME_W'(1);
        endcase
    endfunction

    function automatic void enter_phase(seq_t p);
        seq     = p;
        elapsed = '0;
        case (p)
            SEQ_RST_LOW, SEQ_WR_LOW, SEQ_RD_LOW:
                pin = PIN_LOW;
            SEQ_WR_DATA:
                pin = shreg[bit_pos] ? PIN_HIGH : PIN_LOW;
            SEQ_WR_TAIL:
                pin = PIN_HIGH;
            SEQ_IDLE:
            begin
                // hold the pin as the last slot left it
            end
            default:
                pin = PIN_RELEASED;
        endcase
    endfunction

    function automatic void complete_op();
        done_now = 1'b1;
        completions++;
        enter_phase(SEQ_IDLE);
    endfunction

    function automatic void next_write_bit();
        if (bit_pos == LAST_BIT)
        begin
            complete_op();
        end
        else
        begin
            bit_pos = bit_pos + 1'b1;
            enter_phase(SEQ_WR_LOW);
        end
    endfunction

    function automatic void presence_absent();
        absent = 1'b1;
        absent_count++;
        complete_op();
    endfunction

    function automatic void end_phase();
        case (seq)
            SEQ_RST_LOW:     enter_phase(SEQ_RST_WAIT);
            SEQ_RST_WAIT:    enter_phase(SEQ_RST_POLL);
            SEQ_RST_POLL:    enter_phase(SEQ_RST_RECOVER);
            SEQ_RST_RECOVER: complete_op();
            SEQ_WR_LOW:      enter_phase(SEQ_WR_DATA);
            SEQ_WR_DATA:
            begin
                // a zero bit gets a short driven-high tail before the next slot
                if (shreg[bit_pos])
                    next_write_bit();
                else
                    enter_phase(SEQ_WR_TAIL);
            end
            SEQ_WR_TAIL:     next_write_bit();
            SEQ_RD_LOW:      enter_phase(SEQ_RD_WAIT);
            SEQ_RD_WAIT:     enter_phase(SEQ_RD_SAMPLE);
            SEQ_RD_SAMPLE:   enter_phase(SEQ_RD_TAIL);
            SEQ_RD_TAIL:
            begin
                if (bit_pos == LAST_BIT)
                begin
                    last_read = shreg;
                    complete_op();
                end
                else
                begin
                    bit_pos = bit_pos + 1'b1;
                    enter_phase(SEQ_RD_LOW);
                end
            end
            default:         enter_phase(SEQ_IDLE);
        endcase
    endfunction

    // Skip through phases of zero length until one needs bus time.
    function automatic void settle_phase();
        while (1'b1)
        begin
            if (is_timed(seq) && phase_length(seq) == '0)
                end_phase();
            else if (seq == SEQ_RST_POLL && timing[REG_PRESENCE_TIMEOUT] == '0)
                presence_absent();
            else
                break;
        end
    endfunction

    function automatic void apply_tick(logic level);
        if (seq == SEQ_IDLE)
            return;
        if (seq == SEQ_RST_POLL)
        begin
            if (!level)
            begin
                end_phase();
            end
            else
            begin
                elapsed = elapsed + 1'b1;
                if (elapsed >= timing[REG_PRESENCE_TIMEOUT])
                    presence_absent();
            end
        end
        else if (seq == SEQ_RD_SAMPLE)
        begin
            shreg = {level, shreg[BYTE_W-1:1]};
            end_phase();
        end
        else
        begin
            elapsed = elapsed + 1'b1;
            if (elapsed >= phase_length(seq))
                end_phase();
        end
        settle_phase();
    endfunction

    function automatic res_t bus_step(op_t op, logic [BYTE_W-1:0] data, logic level);
        res_t r;
        done_now = 1'b0;
        if (op == OP_TICK)
        begin
            apply_tick(level);
        end
        else if (seq == SEQ_IDLE)
        begin
            bit_pos = '0;
            case (op)
                OP_RESET:
                begin
                    absent = 1'b0;
                    resets_run++;
                    enter_phase(SEQ_RST_LOW);
                end
                OP_WRITE:
                begin
                    shreg = data;
                    writes_run++;
                    enter_phase(SEQ_WR_LOW);
                end
                default:
                begin
                    shreg = '0;
                    reads_run++;
                    enter_phase(SEQ_RD_LOW);
                end
            endcase
            settle_phase();
        end
        r.drive_mode       = pin;
        r.busy_res         = (seq != SEQ_IDLE);
        r.done_res         = done_now;
        r.read_byte        = last_read;
        r.presence_missing = absent;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            timing[REG_RESET_LOW_TIME]    = RST_RESET_LOW_TIME;
            timing[REG_PRESENCE_DELAY]    = RST_PRESENCE_DELAY;
            timing[REG_PRESENCE_TIMEOUT]  = RST_PRESENCE_TIMEOUT;
            timing[REG_RESET_RECOVERY]    = RST_RESET_RECOVERY;
            timing[REG_WRITE_START_LOW]   = RST_WRITE_START_LOW;
            timing[REG_WRITE_SLOT_TIME]   = RST_WRITE_SLOT_TIME;
            timing[REG_READ_LOW_TIME]     = RST_READ_LOW_TIME;
            timing[REG_READ_SAMPLE_DELAY] = RST_READ_SAMPLE_DELAY;
            seq       = SEQ_IDLE;
            elapsed   = '0;
            bit_pos   = '0;
            shreg     = '0;
            pin       = PIN_RELEASED;
            absent    = 1'b0;
            last_read = '0;
            done_now  = 1'b0;
            awaited_results.delete();
            outstanding <= 0;
            bus_busy    <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                timing[paddr[ADDR_W-1:2]] = pwdata[TIME_W-1:0];

            // retire the oldest prediction before adding this edge's one
            if (res.valid && res.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat arrived with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("drive_mode", 8'(want.drive_mode), 8'(res.drive_mode));
                    compare_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
                    compare_field("done_res", 8'(want.done_res), 8'(res.done_res));
                    compare_field("read_byte", want.read_byte, res.read_byte);
                    compare_field("presence_missing", 8'(want.presence_missing),
                                  8'(res.presence_missing));
                end
            end

            if (cmd.valid && cmd.ready)
                awaited_results.push_back(bus_step(op_t'(cmd.operation), cmd.write_data,
                                                   cmd.line_level));

            outstanding <= awaited_results.size();
            bus_busy    <= (seq != SEQ_IDLE);
        end
    end

endmodule

@@ verif/one_wire_bus_master_tb.sv @@
// Testbench top for the single-wire bus master: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module one_wire_bus_master_tb;
    import owb_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    owb_cmd_if cmd ();
    owb_res_if res ();

    int   mismatches;
    int   outstanding;
    logic bus_busy;
    int   resets_run;
    int   writes_run;
    int   reads_run;
    int   completions;
    int   absent_count;

    int                beats_sent;
    int                gap_max;
    int                stall_max;
    int                low_weight;   // chance in 64 that a tick samples the line low
    bit                want_hold;
    logic [TIME_W-1:0] timing_set [8];

    one_wire_bus_master dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    owb_scoreboard sb (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .res          (res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .bus_busy     (bus_busy),
        .resets_run   (resets_run),
        .writes_run   (writes_run),
        .reads_run    (reads_run),
        .completions  (completions),
        .absent_count (absent_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: stall at random, or for a long stretch when asked.
    initial
    begin
        int hold;
        forever
        begin
            hold = $urandom_range(0, stall_max);
            if (want_hold)
            begin
                hold += HOLD_CYCLES;
                want_hold = 1'b0;
            end
            if (hold > 0)
            begin
                res.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
        end
    end

    function automatic logic line_sample();
        return ($urandom_range(0, 63) >= low_weight);
    endfunction

    task automatic send_beat(input op_t op, input logic [BYTE_W-1:0] data, input logic level);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.operation  <= op;
        cmd.write_data <= data;
        cmd.line_level <= level;
        do @(posedge clk); while (!cmd.ready);
        beats_sent++;
    endtask

    // Tick the bus until the sequencer is idle, then wait for every result beat.
    task automatic quiesce();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (bus_busy)
            send_beat(OP_TICK, BYTE_W'($urandom), line_sample());
        cmd.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_command(input op_t op, input logic [BYTE_W-1:0] data);
        send_beat(op, data, line_sample());
        quiesce();
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing();
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), timing_set[i]);
    endtask

    // Draw each register from its floor up to floor + span.
    task automatic pick_timing(input int span);
        reg_idx_t r;
        int       floor_v;
        for (int i = 0; i < 8; i++)
        begin
            r = reg_idx_t'(i);
            floor_v = (r == REG_PRESENCE_DELAY || r == REG_RESET_RECOVERY ||
                       r == REG_READ_SAMPLE_DELAY) ? 0 : 1;
            timing_set[i] = TIME_W'(floor_v + $urandom_range(0, span));
        end
        program_timing();
    endtask

    task automatic random_beats(input int count);
        int   taken;
        logic was_busy;
        op_t  op;
        taken = 0;
        while (taken < count)
        begin
            was_busy = bus_busy;
            // mostly start a command when idle and tick when busy; the rest is noise
            if (was_busy ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 7) != 0))
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: op = OP_RESET;
                    4, 5, 6:    op = OP_WRITE;
                    default:    op = OP_READ;
                endcase
            end
            else
            begin
                op = OP_TICK;
            end
            send_beat(op, BYTE_W'($urandom), line_sample());
            if (!(was_busy && op != OP_TICK))
                taken++;
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cmd.valid      <= 1'b0;
        cmd.operation  <= OP_TICK;
        cmd.write_data <= '0;
        cmd.line_level <= 1'b1;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        beats_sent = 0;
        gap_max    = 5;
        stall_max  = 5;
        low_weight = 32;
        want_hold  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every register at its floor
        pick_timing(0);
        send_beat(OP_TICK, 8'h00, 1'b0);
        send_beat(OP_TICK, 8'hFF, 1'b1);
        send_beat(OP_RESET, 8'h00, 1'b1);
        send_beat(OP_TICK, 8'h00, 1'b1);
        send_beat(OP_TICK, 8'h00, 1'b0);
        send_beat(OP_RESET, 8'hFF, 1'b0);
        send_beat(OP_WRITE, 8'hFF, 1'b0);
        send_beat(OP_READ, 8'h00, 1'b1);
        send_beat(OP_TICK, 8'h00, 1'b1);
        send_beat(OP_TICK, 8'hFF, 1'b1);
        quiesce();
        run_command(OP_WRITE, 8'h00);
        run_command(OP_WRITE, 8'hFF);
        low_weight = 64;
        run_command(OP_READ, 8'h00);
        low_weight = 32;

        // Stall the result side for a long stretch while beats keep coming
        want_hold = 1'b1;
        random_beats(180);
        quiesce();

        pick_timing(3);
        gap_max   = 0;
        stall_max = 0;
        random_beats(180);
        quiesce();

        pick_timing(6);
        gap_max    = 5;
        stall_max  = 5;
        low_weight = 16;
        random_beats(180);
        quiesce();

        repeat (20) @(posedge clk);
        $display("Sent %0d beats: %0d resets (%0d without presence), %0d writes, %0d reads, %0d done",
                 beats_sent, resets_run, absent_count, writes_run, reads_run, completions);
        $display("Timings run: all floors with a long result stall, then two short random sets");
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/owb_pkg.sv
rtl/core/owb_if.sv
rtl/core/owb_cfg_regs.sv
rtl/core/owb_sequencer.sv
rtl/core/one_wire_bus_master.sv
verif/owb_scoreboard.sv
verif/one_wire_bus_master_tb.sv
